>>> src/cabs_pkg.sv
// Package for the class-aware box suppression block.
// Holds the item structs, stored entry types and the span helper.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package cabs_pkg;

  localparam int DefMaxBoxes = 64;
  localparam int MaxResults = 64;
  localparam int ThrWidth = 9;
  localparam logic [ThrWidth-1:0] ThrReset = 9'd64;

  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] top;
    logic signed [15:0] right;
    logic signed [15:0] bottom;
    logic [15:0] confidence;
    logic [6:0] category;
    logic last;
  } box_in_t;

  typedef struct packed {
    logic signed [15:0] out_left;
    logic signed [15:0] out_top;
    logic signed [15:0] out_right;
    logic signed [15:0] out_bottom;
    logic [15:0] out_confidence;
    logic [6:0] out_category;
    logic out_last;
    logic overflow;
  } box_out_t;

  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] top;
    logic signed [15:0] right;
    logic signed [15:0] bottom;
    logic [15:0] score;
    logic [6:0] category;
  } entry_t;

  typedef struct packed {
    entry_t box;
    logic [31:0] area;
  } kept_t;

  // Length of a side, zero when the far edge is not above the near edge.
  function automatic logic [15:0] span(input logic signed [15:0] lo,
                                       input logic signed [15:0] hi);
    logic [16:0] d;
    d = {hi[15], hi} - {lo[15], lo};
    return (hi > lo) ? d[15:0] : 16'd0;
  endfunction

endpackage
`default_nettype wire

>>> src/class_aware_box_suppression.sv
// Top level of the class-aware greedy box suppression block.
// Uses cabs_pkg for item structs, entry types and the span helper.
//
// Channel   Signals                      Handshake
// input     start, busy, box             taken when start && !busy
// result    strobe, result               one-cycle strobe per item, no stall
// config    cfg_valid, cfg_ready, cfg_data  taken when valid && ready
//
// Placing a box walks the sorted store, S_INS then S_INS_CMP per shifted
// entry. The last item then runs suppression: S_CAND_RD, S_CAND_W and
// S_CAND_A per candidate, S_SUP_RD again if kept, S_SUP_RD and S_SUP_W per
// kept box of another class and all four S_SUP states per kept box of its
// class compared on one shared multiplier, then S_EMIT_RD and S_EMIT_OUT
// per emitted result. Reset is synchronous and clears all control state;
// stores need no clearing. The receiver cannot stall results.
`timescale 1ns / 1ps
`default_nettype none
module class_aware_box_suppression
  import cabs_pkg::*;
#(
  parameter int MAX_BOXES = DefMaxBoxes
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire box_in_t             box,
  output logic                     strobe,
  output box_out_t                 result,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [ThrWidth-1:0] cfg_data
);

  localparam int AW = $clog2(MAX_BOXES);
  localparam int CW = AW + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_INS, S_INS_CMP, S_CAND_RD, S_CAND_W, S_CAND_A,
    S_SUP_RD, S_SUP_W, S_SUP_M1, S_SUP_M2, S_EMIT_RD, S_EMIT_OUT
  } state_t;

  state_t state;
  logic [ThrWidth-1:0] thr;
  logic [CW-1:0] count, idx, ci, kc, k, e;
  logic dropped, last_r;
  entry_t nb, cand;
  logic [31:0] cand_area, inter;
  logic [48:0] prod;

  entry_t st_mem [MAX_BOXES];
  kept_t kp_mem [MAX_BOXES];
  entry_t st_rd;
  kept_t kp_rd;

  logic st_we, kp_we;
  logic [AW-1:0] st_waddr, st_raddr, kp_raddr;
  entry_t st_wdata;
  logic [32:0] mul_a;
  logic [15:0] mul_b;
  logic [32:0] uni;
  logic [CW-1:0] total, idx_m1;
  logic over_res;
  logic signed [15:0] il, it, ir, ib;

  assign busy = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign idx_m1 = idx - CW'(1);
  assign over_res = int'(kc) > MaxResults;
  assign total = over_res ? CW'(MaxResults) : kc;
  assign uni = {1'b0, cand_area} + {1'b0, kp_rd.area} - {1'b0, prod[31:0]};

  always_comb begin
    il = (cand.left > kp_rd.box.left) ? cand.left : kp_rd.box.left;
    it = (cand.top > kp_rd.box.top) ? cand.top : kp_rd.box.top;
    ir = (cand.right < kp_rd.box.right) ? cand.right : kp_rd.box.right;
    ib = (cand.bottom < kp_rd.box.bottom) ? cand.bottom : kp_rd.box.bottom;
  end

  always_comb begin
    st_we = 1'b0;
    st_waddr = idx[AW-1:0];
    st_wdata = nb;
    st_raddr = ci[AW-1:0];
    kp_raddr = k[AW-1:0];
    kp_we = 1'b0;
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_INS: begin
        st_raddr = idx_m1[AW-1:0];
        st_we = (idx == '0);
      end
      S_INS_CMP: begin
        st_we = 1'b1;
        if (st_rd.score < nb.score) begin
          st_wdata = st_rd;
        end
      end
      S_CAND_W: begin
        mul_a = {17'd0, span(st_rd.left, st_rd.right)};
        mul_b = span(st_rd.top, st_rd.bottom);
      end
      S_SUP_RD: begin
        kp_we = (k == kc);
      end
      S_SUP_W: begin
        mul_a = {17'd0, span(il, ir)};
        mul_b = span(it, ib);
      end
      S_SUP_M1: begin
        mul_a = uni;
        mul_b = {7'd0, thr};
      end
      S_EMIT_RD: begin
        kp_raddr = e[AW-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (st_we) begin
      st_mem[st_waddr] <= st_wdata;
    end
    st_rd <= st_mem[st_raddr];
  end

  always_ff @(posedge clk) begin
    if (kp_we) begin
      kp_mem[kc[AW-1:0]] <= '{box: cand, area: cand_area};
    end
    kp_rd <= kp_mem[kp_raddr];
  end

  always_ff @(posedge clk) begin
    prod <= 49'(mul_a) * 49'(mul_b);
    if (rst) begin
      state <= S_IDLE;
      thr <= ThrReset;
      count <= '0;
      dropped <= 1'b0;
      strobe <= 1'b0;
      idx <= '0;
      ci <= '0;
      kc <= '0;
      k <= '0;
      e <= '0;
      last_r <= 1'b0;
    end else begin
      strobe <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        thr <= cfg_data;
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            nb <= '{left: box.left, top: box.top, right: box.right,
                    bottom: box.bottom, score: box.confidence,
                    category: box.category};
            last_r <= box.last;
            ci <= '0;
            kc <= '0;
            if (int'(count) < MAX_BOXES) begin
              idx <= count;
              state <= S_INS;
            end else begin
              dropped <= 1'b1;
              if (box.last) begin
                state <= S_CAND_RD;
              end
            end
          end
        end
        S_INS: begin
          if (idx == '0) begin
            count <= count + CW'(1);
            state <= last_r ? S_CAND_RD : S_IDLE;
          end else begin
            state <= S_INS_CMP;
          end
        end
        S_INS_CMP: begin
          if (st_rd.score < nb.score) begin
            idx <= idx_m1;
            state <= S_INS;
          end else begin
            count <= count + CW'(1);
            state <= last_r ? S_CAND_RD : S_IDLE;
          end
        end
        S_CAND_RD: begin
          if (ci == count) begin
            e <= '0;
            state <= S_EMIT_RD;
          end else begin
            state <= S_CAND_W;
          end
        end
        S_CAND_W: begin
          cand <= st_rd;
          state <= S_CAND_A;
        end
        S_CAND_A: begin
          cand_area <= prod[31:0];
          k <= '0;
          state <= S_SUP_RD;
        end
        S_SUP_RD: begin
          if (k == kc) begin
            kc <= kc + CW'(1);
            ci <= ci + CW'(1);
            state <= S_CAND_RD;
          end else begin
            state <= S_SUP_W;
          end
        end
        S_SUP_W: begin
          if (kp_rd.box.category != cand.category) begin
            k <= k + CW'(1);
            state <= S_SUP_RD;
          end else begin
            state <= S_SUP_M1;
          end
        end
        S_SUP_M1: begin
          inter <= prod[31:0];
          state <= S_SUP_M2;
        end
        S_SUP_M2: begin
          if ({9'd0, inter, 8'd0} > prod) begin
            ci <= ci + CW'(1);
            state <= S_CAND_RD;
          end else begin
            k <= k + CW'(1);
            state <= S_SUP_RD;
          end
        end
        S_EMIT_RD: begin
          if (e == total) begin
            count <= '0;
            dropped <= 1'b0;
            state <= S_IDLE;
          end else begin
            state <= S_EMIT_OUT;
          end
        end
        S_EMIT_OUT: begin
          result <= '{out_left: kp_rd.box.left, out_top: kp_rd.box.top,
                      out_right: kp_rd.box.right, out_bottom: kp_rd.box.bottom,
                      out_confidence: kp_rd.box.score,
                      out_category: kp_rd.box.category,
                      out_last: (e + CW'(1) == total),
                      overflow: dropped | over_res};
          strobe <= 1'b1;
          e <= e + CW'(1);
          state <= S_EMIT_RD;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> busy || $past(state == S_EMIT_OUT)) else $error("stray result");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (int'(count) < MAX_BOXES) |=> busy)
    else $error("item accepted without work");
  a_last_gap: assert property (@(posedge clk) disable iff (rst)
    strobe && result.out_last |=> !strobe) else $error("result after last");
  a_kept_bound: assert property (@(posedge clk) disable iff (rst)
    busy |-> kc <= count) else $error("more kept boxes than stored");

endmodule
`default_nettype wire

>>> bench/testbench.sv
// Self-checking testbench for the class-aware box suppression block.
// Depends on cabs_pkg and class_aware_box_suppression; predicts kept boxes per frame.
`timescale 1ns / 1ps
module testbench;
  import cabs_pkg::*;

  localparam int Cap = 64;
  localparam int WatchLimit = 200000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  box_in_t box = '0;
  logic strobe;
  box_out_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [ThrWidth-1:0] cfg_data = '0;

  class_aware_box_suppression dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .box(box),
    .strobe(strobe), .result(result), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  box_in_t pending_boxes[$];
  box_out_t kept_expected[$];
  entry_t frame_store[Cap];
  int frame_count;
  logic frame_dropped;
  logic [8:0] iou_thr;
  int mismatches, results_seen, frames_done, items_sent, idle_cycles;
  int gap_left;
  logic hold_off;

  function automatic longint side(input logic signed [15:0] lo, input logic signed [15:0] hi);
    return (hi > lo) ? longint'(hi) - longint'(lo) : 0;
  endfunction

  function automatic logic box_overlaps(input entry_t a, input entry_t b);
    longint l, t, r, d, inter, uni;
    if (a.category != b.category) return 1'b0;
    l = (a.left > b.left) ? a.left : b.left;
    t = (a.top > b.top) ? a.top : b.top;
    r = (a.right < b.right) ? a.right : b.right;
    d = (a.bottom < b.bottom) ? a.bottom : b.bottom;
    inter = side(16'(l), 16'(r)) * side(16'(t), 16'(d));
    uni = side(a.left, a.right) * side(a.top, a.bottom)
        + side(b.left, b.right) * side(b.top, b.bottom) - inter;
    return (256 * inter) > (longint'(iou_thr) * uni);
  endfunction

  task automatic predict_box(input box_in_t b);
    int p, total, n;
    logic kept[Cap];
    box_out_t o;
    if (frame_count < Cap) begin
      p = 0;
      while (p < frame_count && frame_store[p].score >= b.confidence) p++;
      for (int i = frame_count; i > p; i--) frame_store[i] = frame_store[i-1];
      frame_store[p] = '{b.left, b.top, b.right, b.bottom, b.confidence, b.category};
      frame_count++;
    end else begin
      frame_dropped = 1'b1;
    end
    if (!b.last) return;
    total = 0;
    for (int i = 0; i < frame_count; i++) begin
      kept[i] = 1'b1;
      for (int j = 0; j < i && kept[i]; j++)
        if (kept[j] && box_overlaps(frame_store[j], frame_store[i])) kept[i] = 1'b0;
      if (kept[i]) total++;
    end
    if (total > MaxResults) begin
      frame_dropped = 1'b1;
      total = MaxResults;
    end
    n = 0;
    for (int i = 0; i < frame_count && n < total; i++) begin
      if (kept[i]) begin
        o.out_left = frame_store[i].left;
        o.out_top = frame_store[i].top;
        o.out_right = frame_store[i].right;
        o.out_bottom = frame_store[i].bottom;
        o.out_confidence = frame_store[i].score;
        o.out_category = frame_store[i].category;
        o.out_last = (n + 1 == total);
        o.overflow = frame_dropped;
        kept_expected.insert(kept_expected.size(), o);
        n++;
      end
    end
    frame_count = 0;
    frame_dropped = 1'b0;
    frames_done++;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Driver: one item at a time from the pending queue.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      gap_left <= 0;
    end else if (start && !busy) begin
      predict_box(box);
      items_sent <= items_sent + 1;
      if (pending_boxes.size() != 0 && !hold_off && pick_gap() == 0) begin
        box <= pending_boxes.pop_front();
      end else begin
        start <= 1'b0;
        gap_left <= pick_gap();
      end
    end else if (!start) begin
      if (gap_left > 0) gap_left <= gap_left - 1;
      else if (pending_boxes.size() != 0 && !hold_off) begin
        box <= pending_boxes.pop_front();
        start <= 1'b1;
      end
    end
  end

  // Monitor: checks each strobed result against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && strobe) begin
      results_seen <= results_seen + 1;
      if (kept_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result %p", result);
      end else if (result !== kept_expected[0]) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Mismatch: expected %p, got %p", kept_expected[0], result);
        void'(kept_expected.pop_front());
      end else begin
        void'(kept_expected.pop_front());
      end
    end
  end

  // Watchdog over cycles with no accepted traffic.
  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe || (cfg_valid && cfg_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("Watchdog expired");
      $display("** class_aware_box_suppression: FAILED **");
      $finish;
    end
  end

  function automatic box_in_t rand_box(input logic lst, input int cats);
    box_in_t b;
    logic signed [15:0] x, y;
    if ($urandom_range(0, 9) == 0) begin
      b.left = 16'($urandom); b.top = 16'($urandom);
      b.right = 16'($urandom); b.bottom = 16'($urandom);
    end else begin
      x = 16'($urandom_range(0, 200) - 100);
      y = 16'($urandom_range(0, 200) - 100);
      b.left = x; b.top = y;
      b.right = 16'(x + $urandom_range(0, 60));
      b.bottom = 16'(y + $urandom_range(0, 60));
    end
    b.confidence = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 3) * 16'h5555)
                                               : 16'($urandom);
    b.category = (cats == 0) ? 7'($urandom) : 7'($urandom_range(0, cats - 1));
    b.last = lst;
    return b;
  endfunction

  task automatic wait_drained();
    while (pending_boxes.size() != 0 || start || busy || kept_expected.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_thr(input logic [8:0] v);
    @(posedge clk);
    cfg_data <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    iou_thr = v;
  endtask

  task automatic add_pending(input box_in_t b);
    pending_boxes.insert(pending_boxes.size(), b);
  endtask

  task automatic push_frame(input int n, input int cats);
    for (int i = 0; i < n; i++) add_pending(rand_box(i == n - 1, cats));
  endtask

  initial begin
    box_in_t b;
    logic [8:0] thr_list[5];
    thr_list = '{9'd0, 9'd256, 9'd511, 9'd128, 9'd64};
    mismatches = 0; results_seen = 0; frames_done = 0; items_sent = 0;
    frame_count = 0; frame_dropped = 1'b0; iou_thr = ThrReset; hold_off = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: extremes, identical boxes, inverted and zero-area boxes, ties.
    b = '{16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'hffff, 7'h7f, 1'b0};
    add_pending(b);
    b.confidence = 16'h0000; add_pending(b);
    b = '{16'sd10, 16'sd10, 16'sd0, 16'sd0, 16'h8000, 7'd0, 1'b0};
    add_pending(b);
    add_pending(b);
    b = '{16'sd0, 16'sd0, 16'sd20, 16'sd20, 16'h8000, 7'd1, 1'b0};
    add_pending(b);
    b.category = 7'd2; add_pending(b);
    b.category = 7'd1; b.left = 16'sd5; add_pending(b);
    b = '{16'sd3, 16'sd3, 16'sd3, 16'sd3, 16'h1234, 7'd5, 1'b1};
    add_pending(b);
    b.last = 1'b1; add_pending(b);
    wait_drained();

    // Overflow: one frame beyond store capacity, all kept at a threshold of 256.
    write_thr(9'd256);
    push_frame(Cap + 3, 0);
    wait_drained();

    foreach (thr_list[k]) begin
      write_thr(thr_list[k]);
      for (int f = 0; f < 6; f++) push_frame($urandom_range(1, 8), $urandom_range(1, 3));
      wait_drained();
    end
    write_thr(9'($urandom_range(0, 300)));
    for (int f = 0; f < 5; f++) push_frame($urandom_range(1, 12), 0);
    wait_drained();

    $display("Ran %0d items in %0d frames, %0d kept boxes checked, thresholds 0..511.",
             items_sent, frames_done, results_seen);
    if (mismatches == 0 && kept_expected.size() == 0) begin
      $display("** class_aware_box_suppression: PASSED **");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("** class_aware_box_suppression: FAILED **");
    end
    $finish;
  end

endmodule
